/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/nqpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqpt_pkg
// widths, codes and helpers for the nvme queue pair tracker
// ----------------------------------------------------------------------------
package nqpt_pkg;

   localparam int MAX_RING_DEPTH = 4096;
   localparam int DEPTH_CAP_RAW  = (MAX_RING_DEPTH < 4096) ? MAX_RING_DEPTH : 4096;
   localparam int DEPTH_CAP      = (DEPTH_CAP_RAW < 2) ? 2 : DEPTH_CAP_RAW;

   localparam int CMD_ID_W = 16;
   localparam int IDX_W    = 12;
   localparam int DEPTH_W  = 13;
   localparam int WAIT_W   = 20;
   localparam int STATUS_W = 15;
   localparam int PADDR_W  = 4;
   localparam int PDATA_W  = 32;

   localparam logic [CMD_ID_W-1:0] CMD_ID_WRAP    = 16'hFFFF;
   localparam logic [WAIT_W-1:0]   WAIT_MAX       = 20'hFFFFF;
   localparam logic [DEPTH_W-1:0]  SQ_ENTRIES_RST = 13'd64;
   localparam logic [DEPTH_W-1:0]  CQ_ENTRIES_RST = 13'd256;
   localparam logic [WAIT_W-1:0]   TIMEOUT_RST    = 20'd500000;
   localparam logic [DEPTH_W-1:0]  DEPTH_MIN      = 13'd2;
   localparam logic [DEPTH_W-1:0]  DEPTH_MAX      = DEPTH_W'(DEPTH_CAP);

   typedef enum logic [0:0] {
      OP_SUBMIT = 1'b0,
      OP_POLL   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_SUBMITTED = 2'd0,
      KIND_COMPLETED = 2'd1,
      KIND_WAITING   = 2'd2,
      KIND_TIMED_OUT = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      REG_SQ_ENTRIES    = 2'd0,
      REG_CQ_ENTRIES    = 2'd1,
      REG_TIMEOUT_LIMIT = 2'd2
   } reg_index_type;

   // clamp a programmed ring depth into the supported range
   function automatic logic [DEPTH_W-1:0] eff_depth(input logic [DEPTH_W-1:0] v);
      logic [DEPTH_W-1:0] d;
      d = v;
      if (d < DEPTH_MIN) d = DEPTH_MIN;
      if (d > DEPTH_MAX) d = DEPTH_MAX;
      return d;
   endfunction

endpackage

/* rtl/nqpt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqpt channel interfaces
// valid/ready request and result channels of the queue pair tracker
// ----------------------------------------------------------------------------
interface nqpt_req_if;
   import nqpt_pkg::*;

   logic                valid;
   logic                ready;
   logic                opcode;
   logic                entry_phase;
   logic [STATUS_W-1:0] entry_status;

   modport source (output valid, opcode, entry_phase, entry_status, input ready);
   modport sink   (input valid, opcode, entry_phase, entry_status, output ready);
endinterface

interface nqpt_rsp_if;
   import nqpt_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          result_kind;
   logic [CMD_ID_W-1:0] command_id;
   logic [IDX_W-1:0]    sq_slot;
   logic [IDX_W-1:0]    sq_doorbell;
   logic [IDX_W-1:0]    cq_doorbell;
   logic [STATUS_W-1:0] completion_status;

   modport source (output valid, result_kind, command_id, sq_slot, sq_doorbell,
                   cq_doorbell, completion_status, input ready);
   modport sink   (input valid, result_kind, command_id, sq_slot, sq_doorbell,
                   cq_doorbell, completion_status, output ready);
endinterface

/* rtl/nvme_queue_pair_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvme_queue_pair_tracker_unit
// Host-side tracker for one submission/completion queue pair. A submit
// request gets the next command id (0..65534, then 0) and the tail slot, and
// returns the new tail as the submission doorbell. A poll request carries the
// phase and status of the completion entry at the head; on a phase match the
// head advances (phase flips on wrap) and the new head is the completion
// doorbell, otherwise the wait counter grows and a timeout is reported once
// it has passed timeout_limit. Every request gives one result. One request
// is taken per clock unless a waiting result is held by rsp.ready; a
// request passes the input register, then the pointer/counter update stage
// into the result register, and one more request is held while a result
// waits. Registers (APB, 32-bit, byte addresses): 0x0 sq_entries, 0x4
// cq_entries, 0x8 timeout_limit; write only while no request is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nvme_queue_pair_tracker_unit (
   input  logic                           clock,
   input  logic                           reset,
   nqpt_req_if.sink                       req,
   nqpt_rsp_if.source                     rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [nqpt_pkg::PADDR_W-1:0]   paddr,
   input  logic [nqpt_pkg::PDATA_W-1:0]   pwdata,
   output logic [nqpt_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);
   import nqpt_pkg::*;

   // configuration
   logic [DEPTH_W-1:0]  sq_entries_ff;
   logic [DEPTH_W-1:0]  cq_entries_ff;
   logic [WAIT_W-1:0]   timeout_limit_ff;
   logic                cfg_write;
   reg_index_type       reg_index;

   // tracker state
   logic [CMD_ID_W-1:0] next_id_ff,        next_id_in;
   logic [IDX_W-1:0]    tail_ff,           tail_in;
   logic [IDX_W-1:0]    head_ff,           head_in;
   logic                exp_phase_ff,      exp_phase_in;
   logic [WAIT_W-1:0]   wait_count_ff,     wait_count_in;

   // input stage
   logic                in_valid_ff;
   logic                opcode_ff;
   logic                phase_ff;
   logic [STATUS_W-1:0] status_ff;

   // result stage
   logic                out_valid_ff;
   result_kind_type     kind_ff,           kind_in;
   logic [CMD_ID_W-1:0] cmd_id_ff,         cmd_id_in;
   logic [IDX_W-1:0]    sq_slot_ff,        sq_slot_in;
   logic [IDX_W-1:0]    sq_db_ff,          sq_db_in;
   logic [IDX_W-1:0]    cq_db_ff,          cq_db_in;
   logic [STATUS_W-1:0] cstat_ff,          cstat_in;

   logic                advance;
   logic [DEPTH_W-1:0]  tail_inc;
   logic [DEPTH_W-1:0]  head_inc;
   logic [CMD_ID_W-1:0] id_inc;

   // ---------------------------------------------------------------- csr
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign reg_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_entries_ff    <= SQ_ENTRIES_RST;
         cq_entries_ff    <= CQ_ENTRIES_RST;
         timeout_limit_ff <= TIMEOUT_RST;
      end else if (cfg_write) begin
         case (reg_index)
            REG_SQ_ENTRIES:    sq_entries_ff    <= pwdata[DEPTH_W-1:0];
            REG_CQ_ENTRIES:    cq_entries_ff    <= pwdata[DEPTH_W-1:0];
            REG_TIMEOUT_LIMIT: timeout_limit_ff <= pwdata[WAIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_SQ_ENTRIES:    prdata = PDATA_W'(sq_entries_ff);
         REG_CQ_ENTRIES:    prdata = PDATA_W'(cq_entries_ff);
         REG_TIMEOUT_LIMIT: prdata = PDATA_W'(timeout_limit_ff);
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         opcode_ff <= req.opcode;
         phase_ff  <= req.entry_phase;
         status_ff <= req.entry_status;
      end
   end

   // ----------------------------------------------------- update logic
   assign id_inc   = next_id_ff + 1'b1;
   assign tail_inc = {1'b0, tail_ff} + 1'b1;
   assign head_inc = {1'b0, head_ff} + 1'b1;

   always_comb begin
      next_id_in    = next_id_ff;
      tail_in       = tail_ff;
      head_in       = head_ff;
      exp_phase_in  = exp_phase_ff;
      wait_count_in = wait_count_ff;
      kind_in       = KIND_WAITING;
      cmd_id_in     = '0;
      sq_slot_in    = '0;
      sq_db_in      = '0;
      cq_db_in      = '0;
      cstat_in      = '0;

      if (opcode_ff == OP_SUBMIT) begin
         // id 0xffff is never handed out
         next_id_in    = (id_inc == CMD_ID_WRAP) ? '0 : id_inc;
         tail_in       = (tail_inc >= eff_depth(sq_entries_ff)) ? '0 : tail_inc[IDX_W-1:0];
         wait_count_in = '0;
         kind_in       = KIND_SUBMITTED;
         cmd_id_in     = next_id_ff;
         sq_slot_in    = tail_ff;
         sq_db_in      = tail_in;
      end else if (phase_ff == exp_phase_ff) begin
         if (head_inc >= eff_depth(cq_entries_ff)) begin
            head_in      = '0;
            exp_phase_in = !exp_phase_ff;
         end else begin
            head_in      = head_inc[IDX_W-1:0];
         end
         wait_count_in = '0;
         kind_in       = KIND_COMPLETED;
         cq_db_in      = head_in;
         cstat_in      = status_ff;
      end else if (wait_count_ff > timeout_limit_ff) begin
         wait_count_in = '0;
         kind_in       = KIND_TIMED_OUT;
      end else begin
         if (wait_count_ff < WAIT_MAX) wait_count_in = wait_count_ff + 1'b1;
         kind_in       = KIND_WAITING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff    <= '0;
         tail_ff       <= '0;
         head_ff       <= '0;
         exp_phase_ff  <= 1'b1;
         wait_count_ff <= '0;
      end else if (advance) begin
         next_id_ff    <= next_id_in;
         tail_ff       <= tail_in;
         head_ff       <= head_in;
         exp_phase_ff  <= exp_phase_in;
         wait_count_ff <= wait_count_in;
      end
   end

   // ------------------------------------------------------- result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff    <= kind_in;
         cmd_id_ff  <= cmd_id_in;
         sq_slot_ff <= sq_slot_in;
         sq_db_ff   <= sq_db_in;
         cq_db_ff   <= cq_db_in;
         cstat_ff   <= cstat_in;
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.result_kind       = kind_ff;
   assign rsp.command_id        = cmd_id_ff;
   assign rsp.sq_slot           = sq_slot_ff;
   assign rsp.sq_doorbell       = sq_db_ff;
   assign rsp.cq_doorbell       = cq_db_ff;
   assign rsp.completion_status = cstat_ff;

   // ---------------------------------------------------------- checks
   `ASSERT_NEXT(a_held_request_kept, in_valid_ff && !advance, in_valid_ff, "held request dropped")
   `ASSERT_NEXT(a_advance_fills_result, advance, out_valid_ff, "advanced request lost")
   `ASSERT_IMPLIES(a_id_never_wrap_code, 1'b1, next_id_ff != CMD_ID_WRAP, "reserved command id")
   `ASSERT_IMPLIES(a_submit_no_cq_fields, out_valid_ff && kind_ff == KIND_SUBMITTED, cq_db_ff == '0 && cstat_ff == '0, "submit result carries completion fields")

endmodule
